// File: sv/signed_int_to_radix_symbols_top_assert.svh
// Assertion macros for the signed integer to radix symbols block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef SIGNED_INT_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH

// property must hold at every clock edge out of reset
`define SIRS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define SIRS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/sirs_pkg.sv
// Shared types, constants and helper functions of the radix symbol converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sirs_pkg;

	localparam int MAX_SYMBOLS = 16;
	localparam int NUM_SYMBOLS = 16;
	localparam int NUM_DIGITS  = 32;
	localparam int VALUE_W     = 32;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QDEPTH      = 2;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMS_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMS_HI  = 2'd2;

	typedef struct packed {
		logic [RADIX_W-1:0]               radix;
		logic [NUM_SYMBOLS-1:0][7:0]      symbols;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

	function automatic logic [7:0] sym_at(cfg_t c, logic [DIGIT_W-1:0] idx);
		return c.symbols[idx];
	endfunction

	function automatic logic alphabet_ok(cfg_t c);
		logic ok;
		ok = (c.radix > RADIX_W'(1)) && (c.radix <= RADIX_W'(MAX_SYMBOLS));
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			if (RADIX_W'(i) < c.radix) begin
				if (c.symbols[i] == SYM_PLUS || c.symbols[i] == SYM_MINUS) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
					if (RADIX_W'(j) < c.radix && c.symbols[j] == c.symbols[i]) begin
						ok = 1'b0;
					end
				end
			end
		end
		return ok;
	endfunction

endpackage

// File: sv/sirs_queue.sv
// Short request queue between the classifying front end and the converter.
// Depends on sirs_pkg for the item type and depth.
`timescale 1ns / 1ps

module sirs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sirs_pkg::item_t  push_item,
	input  logic             pop,
	output sirs_pkg::item_t  pop_item,
	output sirs_pkg::q_stat_t stat
);

	localparam int PTR_W = (sirs_pkg::QDEPTH > 1) ? $clog2(sirs_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(sirs_pkg::QDEPTH + 1);

	sirs_pkg::item_t   mem_q [sirs_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(sirs_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(sirs_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// File: sv/sirs_front.sv
// Front end: accepts requests, checks the alphabet, forms sign and magnitude.
// Depends on sirs_pkg; feeds sirs_queue.
`timescale 1ns / 1ps

module sirs_front (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sirs_pkg::VALUE_W-1:0] value,
	input  sirs_pkg::cfg_t                    cfg,
	input  sirs_pkg::q_stat_t                 q_stat,
	output logic                              push,
	output sirs_pkg::item_t                   push_item
);

	logic [sirs_pkg::VALUE_W-1:0] raw;

	assign raw      = $unsigned(value);
	assign in_ready = !q_stat.full;

	// drop requests when the alphabet is unusable
	assign push = in_valid && !q_stat.full && sirs_pkg::alphabet_ok(cfg);

	assign push_item.neg = raw[sirs_pkg::VALUE_W-1];
	assign push_item.mag = raw[sirs_pkg::VALUE_W-1] ? (~raw + sirs_pkg::VALUE_W'(1)) : raw;

endmodule

// File: sv/sirs_back.sv
// Back end: shift-and-adjust conversion to base-radix digits, then symbol emit.
// Depends on sirs_pkg; pulls requests from sirs_queue.
`timescale 1ns / 1ps

module sirs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sirs_pkg::cfg_t      cfg,
	input  sirs_pkg::q_stat_t   q_stat,
	input  sirs_pkg::item_t     pop_item,
	output logic                pop,
	output sirs_pkg::back_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          symbol,
	output logic                is_last
);

	localparam int ND    = sirs_pkg::NUM_DIGITS;
	localparam int DW    = sirs_pkg::DIGIT_W;
	localparam int RW    = sirs_pkg::RADIX_W;
	localparam int VW    = sirs_pkg::VALUE_W;
	localparam int KW    = $clog2(ND);
	localparam int TOP_W = $clog2(ND + 1);
	localparam int CNT_W = $clog2(VW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic               neg_q;
	logic [VW-1:0]      mag_q;
	logic [DW-1:0]      digits_q [ND];
	logic [TOP_W-1:0]   top_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KW-1:0]      k_q;
	logic               out_valid_q;
	logic [7:0]         symbol_q;
	logic               is_last_q;

	logic [ND-1:0]      gen;
	logic [ND-1:0]      prop;
	logic [ND:0]        sum;
	logic [ND:0]        carry;
	logic [DW-1:0]      digits_nx [ND];
	logic [TOP_W-1:0]   top_nx;
	logic               slot_free;
	logic               conv_done;
	logic               emit;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign stat.idle = (state_q == ST_IDLE);
	assign conv_done = (cnt_q == CNT_W'(VW - 1));
	assign emit      = ((state_q == ST_SIGN) || (state_q == ST_EMIT)) && slot_free;

	// one bit of the magnitude enters per cycle; carries ripple as a wide add
	always_comb begin
		logic [RW-1:0] two_d;
		logic [RW-1:0] t;
		for (int i = 0; i < ND; i++) begin
			two_d   = {digits_q[i], 1'b0};
			gen[i]  = (two_d >= cfg.radix);
			prop[i] = (two_d == cfg.radix - RW'(1));
		end
		sum = {1'b0, gen | prop} + {1'b0, gen} + (ND + 1)'(mag_q[VW-1]);
		for (int i = 0; i < ND; i++) begin
			carry[i] = sum[i] ^ (gen[i] | prop[i]) ^ gen[i];
		end
		carry[ND] = sum[ND];
		for (int i = 0; i < ND; i++) begin
			two_d = {digits_q[i], 1'b0};
			t     = two_d + RW'(carry[i]);
			digits_nx[i] = carry[i + 1] ? DW'(t - cfg.radix) : t[DW-1:0];
		end
		top_nx = top_q + TOP_W'(carry[top_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			top_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						neg_q   <= pop_item.neg;
						top_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					top_q <= top_nx;
					cnt_q <= cnt_q + CNT_W'(1);
					if (conv_done) begin
						k_q     <= (top_nx == '0) ? '0 : KW'(top_nx - TOP_W'(1));
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (k_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q - KW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q <= pop_item.mag;
			for (int i = 0; i < ND; i++) begin
				digits_q[i] <= '0;
			end
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VW-2:0], 1'b0};
			for (int i = 0; i < ND; i++) begin
				digits_q[i] <= digits_nx[i];
			end
		end
		if (state_q == ST_SIGN && slot_free) begin
			symbol_q  <= sirs_pkg::SYM_MINUS;
			is_last_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			symbol_q  <= sirs_pkg::sym_at(cfg, digits_q[k_q]);
			is_last_q <= (k_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign is_last   = is_last_q;

endmodule

// File: sv/signed_int_to_radix_symbols_top.sv
// Top level of the signed integer to radix symbols converter.
// Holds the configuration registers; depends on sirs_pkg, sirs_front,
// sirs_queue and sirs_back.
//
//   channel   signals                          width   direction
//   in        in_valid/in_ready, value         32      into block
//   out       out_valid/out_ready, symbol,     8 + 1   out of block
//             is_last
//   cfg       cfg_we, cfg_index, cfg_data      2, 64   into block
//
// A request is popped from the queue, converted by one shift-and-adjust step
// per magnitude bit, then emitted as 1 to 33 symbols (optional sign, digits).
// The front end takes requests while the converter works, up to two queued.
// A full queue holds in_ready low; a stalled output holds the emit sequence.
// Reset clears radix and the alphabet; an alphabet that fails the check
// swallows requests with no symbols.
`timescale 1ns / 1ps
`include "signed_int_to_radix_symbols_top_assert.svh"

module signed_int_to_radix_symbols_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sirs_pkg::VALUE_W-1:0]   value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            symbol,
	output logic                                  is_last,
	input  logic                                  cfg_we,
	input  logic [sirs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sirs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	sirs_pkg::cfg_t       cfg_q;
	sirs_pkg::q_stat_t    q_stat;
	sirs_pkg::item_t      push_item;
	sirs_pkg::item_t      pop_item;
	sirs_pkg::back_stat_t back_stat;
	logic                 push;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sirs_pkg::REG_RADIX:    cfg_q.radix <= cfg_data[sirs_pkg::RADIX_W-1:0];
				sirs_pkg::REG_SYMS_LOW: cfg_q.symbols[7:0] <= cfg_data;
				sirs_pkg::REG_SYMS_HI:  cfg_q.symbols[15:8] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sirs_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	sirs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	sirs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.stat      (back_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.is_last   (is_last)
	);

	`SIRS_NEVER(a_no_overflow, push && q_stat.full && !pop, "request pushed into full queue")
	`SIRS_NEVER(a_no_underflow, pop && q_stat.empty, "request popped from empty queue")
	`SIRS_CHECK(a_pop_when_idle, pop |-> back_stat.idle, "pop while converter busy")
	`SIRS_CHECK(a_busy_after_pop, pop |=> !back_stat.idle, "converter did not start")

endmodule
